// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each check samples on clk_i and is
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds on every clock edge outside reset.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that a condition is never true outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, cond)

`endif

`endif

// ----- rtl/u2u_pkg.sv -----
package u2u_pkg;

  // Outcome code carried in the status word of a run.
  typedef enum logic [1:0] {
    ST_COMPLETE  = 2'd0,
    ST_STOPPED   = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_e;

  // Register index, taken from paddr bit 2.
  localparam logic REG_MAX_CHARS  = 1'b0;
  localparam logic REG_COUNT_ONLY = 1'b1;

  localparam logic [15:0] MAX_CHARS_RST = 16'hFFFF;

  // Decoder queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One queue entry: what a single accepted byte leaves to emit.
  typedef struct packed {
    logic        unit_vld;
    logic [15:0] code_unit;
    logic        stat_vld;
    status_e     status;
    logic [15:0] char_count;
  } u2u_entry_t;

endpackage

// ----- rtl/utf8_to_ucs2_decoder.sv -----
// Channel   Dir  Payload                                      Ends on
// s_*       in   tdata[7:0] data_byte, tlast last              s_tvalid & s_tready
// m_*       out  tdata code_unit/char_count, tlast end_of_run, m_tvalid & m_tready
//                tuser status
// APB       in   0x0 max_chars[15:0], 0x4 count_only[0]         psel & penable
//
// Throughput: one source byte per clock while the queue has room; a byte that
// closes a run with a character yields a code unit word, then a status word.
// Path: the byte is decoded and written to the queue at its accepting edge, and
// the queue head moves into the output register once that register is free or
// its word is taken on m_*.
// Stalls: a four-entry queue parts front and back; s_tready drops only while
// it is full, so back pressure on m_* reaches s_* after the queue fills.
// Reset: asynchronous, clears run state, queue and output valid; max_chars
// returns to 0xFFFF, count_only to 0.
module utf8_to_ucs2_decoder
  import u2u_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic        s_tlast,    // last
  // code unit stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [15:0] code_unit, [31:16] char_count
  output logic        m_tlast,    // end_of_run
  output logic [1:0]  m_tuser,    // [1:0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] max_chars_q;
  logic        count_only_q;
  logic        cfg_wr;

  logic        s_accept;
  logic        push, pop, full, empty;
  u2u_entry_t  push_data, head;

  // Register file: index from paddr bit 2, low bits ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q  <= MAX_CHARS_RST;
      count_only_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MAX_CHARS:  max_chars_q  <= pwdata[15:0];
        REG_COUNT_ONLY: count_only_q <= pwdata[0];
        default:        max_chars_q  <= max_chars_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_CHARS:  prdata = {16'b0, max_chars_q};
      REG_COUNT_ONLY: prdata = {31'b0, count_only_q};
      default:        prdata = '0;
    endcase
  end

  // Front takes a byte whenever the queue has room.
  assign s_tready = !full;
  assign s_accept = s_tvalid && s_tready;

  u2u_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (s_accept),
    .data_byte_i  (s_tdata),
    .last_i       (s_tlast),
    .max_chars_i  (max_chars_q),
    .count_only_i (count_only_q),
    .push_o       (push),
    .entry_o      (push_data)
  );

  u2u_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  // Back drains entries into the output register, one word per cycle while the receiver takes them.
  u2u_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .empty_i  (empty),
    .pop_o    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

`include "assert_macros.svh"
  `ASSERT_PROP(a_ready_when_room, !full |-> s_tready)

endmodule

// ----- rtl/u2u_queue.sv -----
module u2u_queue
  import u2u_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  u2u_entry_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output u2u_entry_t head_o,
  output logic       empty_o
);

  u2u_entry_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]      cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`include "assert_macros.svh"
  `ASSERT_NEVER(a_no_push_full, push_i && full_o)
  `ASSERT_NEVER(a_no_pop_empty, pop_i && empty_o)

endmodule

// ----- rtl/u2u_front.sv -----
module u2u_front
  import u2u_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic [15:0] max_chars_i,
  input  logic        count_only_i,
  output logic        push_o,
  output u2u_entry_t  entry_o
);

  localparam int unsigned WB = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [1:0]            pend_q, pend_d;
  logic [15:0]           part_q, part_d;
  logic                  stop_q, stop_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  over_q, over_d;

  logic                  have;
  logic [15:0]           ch;
  logic                  below_max;
  logic [WB-1:0]         cnt_ext;

  assign below_max = (WB'(cnt_q) < WB'(max_chars_i));

  always_comb begin
    pend_d  = pend_q;
    part_d  = part_q;
    stop_d  = stop_q;
    cnt_d   = cnt_q;
    over_d  = over_q;
    have    = 1'b0;
    ch      = '0;
    entry_o = '0;

    if (!stop_q) begin
      if (pend_q == 2'd0) begin
        if (!data_byte_i[7]) begin
          if (data_byte_i != 8'h00) begin
            ch   = {8'h00, data_byte_i};
            have = 1'b1;
          end else begin
            stop_d = 1'b1;
          end
        end else if (data_byte_i[7:5] == 3'b110) begin
          part_d = {5'b0, data_byte_i[4:0], 6'b0};
          pend_d = 2'd1;
        end else if (data_byte_i[7:4] == 4'b1110) begin
          part_d = {data_byte_i[3:0], 12'b0};
          pend_d = 2'd2;
        end else begin
          stop_d = 1'b1;
        end
      end else if (data_byte_i[7:6] != 2'b10) begin
        stop_d = 1'b1;
        pend_d = 2'd0;
        part_d = '0;
      end else if (pend_q == 2'd2) begin
        part_d = part_q | {4'b0, data_byte_i[5:0], 6'b0};
        pend_d = 2'd1;
      end else begin
        ch     = part_q | {10'b0, data_byte_i[5:0]};
        have   = 1'b1;
        pend_d = 2'd0;
        part_d = '0;
      end
    end

    if (have) begin
      if (!count_only_i) begin
        if (below_max) begin
          entry_o.unit_vld  = 1'b1;
          entry_o.code_unit = ch;
        end else begin
          over_d = 1'b1;
        end
      end
      if (!(&cnt_q)) begin
        cnt_d = cnt_q + 1'b1;
      end
    end

    cnt_ext = WB'(cnt_d);
    if (last_i) begin
      entry_o.stat_vld   = 1'b1;
      entry_o.status     = over_d ? ST_TRUNCATED : (stop_d ? ST_STOPPED : ST_COMPLETE);
      entry_o.char_count = (cnt_ext > WB'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];
      pend_d = 2'd0;
      part_d = '0;
      stop_d = 1'b0;
      cnt_d  = '0;
      over_d = 1'b0;
    end
  end

  assign push_o = accept_i && (entry_o.unit_vld || entry_o.stat_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      part_q <= '0;
      stop_q <= 1'b0;
      cnt_q  <= '0;
      over_q <= 1'b0;
    end else if (accept_i) begin
      pend_q <= pend_d;
      part_q <= part_d;
      stop_q <= stop_d;
      cnt_q  <= cnt_d;
      over_q <= over_d;
    end
  end

`include "assert_macros.svh"
  `ASSERT_NEVER(a_pend_legal, pend_q == 2'd3)
  `ASSERT_PROP(a_stop_idle, stop_q |-> (pend_q == 2'd0 && part_q == '0))

endmodule

// ----- rtl/u2u_back.sv -----
module u2u_back
  import u2u_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  u2u_entry_t  head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic        m_tlast,
  output logic [1:0]  m_tuser
);

  logic        out_vld_q;
  logic [15:0] unit_q, cnt_q;
  logic        last_q;
  status_e     stat_q;
  logic        phase_q;   // unit word of the head entry already sent
  logic        load;
  logic        send_unit;

  assign load      = !empty_i && (!out_vld_q || m_tready);
  assign send_unit = head_i.unit_vld && !phase_q;
  // Pop once the final word of the entry goes out.
  assign pop_o     = load && !(send_unit && head_i.stat_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      phase_q   <= 1'b0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
        phase_q   <= !pop_o;
      end else if (m_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (send_unit) begin
        unit_q <= head_i.code_unit;
        cnt_q  <= '0;
        last_q <= 1'b0;
        stat_q <= ST_COMPLETE;
      end else begin
        unit_q <= '0;
        cnt_q  <= head_i.char_count;
        last_q <= 1'b1;
        stat_q <= head_i.status;
      end
    end
  end

  assign m_tvalid = out_vld_q;
  assign m_tdata  = {cnt_q, unit_q};
  assign m_tlast  = last_q;
  assign m_tuser  = stat_q;

`include "assert_macros.svh"
  `ASSERT_PROP(a_phase_has_head, phase_q |-> (!empty_i && head_i.stat_vld))

endmodule

// ----- tb/tb_utf8_to_ucs2_decoder.sv -----
`timescale 1ns / 1ps

module tb_utf8_to_ucs2_decoder;
  import u2u_pkg::*;

  localparam int QUIET_LIMIT = 2000;   // cycles with no word moving on any port
  localparam int RANDOM_BYTES = 1100;

  // One word as it leaves the m_* side.
  typedef struct {
    logic [15:0] code_unit;
    logic        end_of_run;
    status_e     status;
    logic [15:0] char_count;
  } decoded_word_t;

  // Receiver behaviour, redrawn at random when the current mode's span runs out.
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_CHOKED} sink_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Register copies, at their reset values.
  logic [15:0] cfg_max_chars = MAX_CHARS_RST;
  logic        cfg_count_only = 1'b0;

  // Decoder state of the current run.
  logic [1:0]  seq_left = 2'd0;
  logic [15:0] seq_bits = 16'd0;
  logic        run_halted = 1'b0;
  logic [15:0] run_count = 16'd0;
  logic        run_truncated = 1'b0;

  decoded_word_t expected_words[$];
  logic [7:0]    run_bytes[$];

  int fail_count = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  bit steady_source = 1'b0;

  utf8_to_ucs2_decoder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [7:0] data_byte
    .s_tlast  (s_tlast),    // last
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [15:0] code_unit, [31:16] char_count
    .m_tlast  (m_tlast),    // end_of_run
    .m_tuser  (m_tuser),    // [1:0] status
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: advance the run state by one source byte and queue whatever
  // words that byte should produce.
  // ---------------------------------------------------------------------------
  task automatic decode_byte(input logic [7:0] b, input logic lst);
    logic          got;
    logic [15:0]   ch;
    decoded_word_t w;
    got = 1'b0;
    ch = 16'd0;
    if (!run_halted) begin
      if (seq_left == 2'd0) begin
        if (!b[7]) begin
          // a zero byte ends decoding just like a bad lead
          if (b != 8'h00) begin
            ch = {8'h00, b};
            got = 1'b1;
          end else begin
            run_halted = 1'b1;
          end
        end else if (b[7:5] == 3'b110) begin
          seq_bits = {5'd0, b[4:0], 6'd0};
          seq_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          seq_bits = {b[3:0], 12'd0};
          seq_left = 2'd2;
        end else begin
          run_halted = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        // broken continuation: drop the partial character and halt
        run_halted = 1'b1;
        seq_left = 2'd0;
        seq_bits = 16'd0;
      end else if (seq_left == 2'd2) begin
        seq_bits = seq_bits | {4'd0, b[5:0], 6'd0};
        seq_left = 2'd1;
      end else begin
        ch = seq_bits | {10'd0, b[5:0]};
        got = 1'b1;
        seq_left = 2'd0;
        seq_bits = 16'd0;
      end
    end

    if (got) begin
      // count-only mode never emits and never marks the run truncated
      if (!cfg_count_only) begin
        if (run_count < cfg_max_chars) begin
          w.code_unit = ch;
          w.end_of_run = 1'b0;
          w.status = ST_COMPLETE;
          w.char_count = 16'd0;
          expected_words.push_back(w);
        end else begin
          run_truncated = 1'b1;
        end
      end
      // saturate rather than wrap
      if (run_count != 16'hFFFF) run_count = run_count + 16'd1;
    end

    if (lst) begin
      // truncation outranks a stop; a cut-off sequence leaves no trace
      w.code_unit = 16'd0;
      w.end_of_run = 1'b1;
      w.status = run_truncated ? ST_TRUNCATED : (run_halted ? ST_STOPPED : ST_COMPLETE);
      w.char_count = run_count;
      expected_words.push_back(w);
      seq_left = 2'd0;
      seq_bits = 16'd0;
      run_halted = 1'b0;
      run_count = 16'd0;
      run_truncated = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Source side. Entered and left at a falling edge; valid stays high between
  // back-to-back bytes and drops only for a gap between bursts.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    if (!steady_source && burst_left == 0) begin
      gap = $urandom_range(1, 15);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= lst;
    do @(posedge clk_i); while (!s_tready);
    decode_byte(b, lst);
    @(negedge clk_i);
  endtask

  // Send run_bytes as one run, last on the final byte.
  task automatic send_run();
    for (int i = 0; i < run_bytes.size(); i++)
      send_byte(run_bytes[i], i == run_bytes.size() - 1);
  endtask

  // Hold the source off until every expected word has arrived, then let the
  // pipeline settle.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register, mirror it, and read it back.
  task automatic set_register(input logic idx, input logic [15:0] value);
    logic [31:0] wdata;
    logic [31:0] rd;
    wdata = (idx == REG_MAX_CHARS) ? {16'd0, value} : {31'd0, value[0]};
    apb_xfer(1'b1, {idx, 2'b00}, wdata, rd);
    if (idx == REG_MAX_CHARS) cfg_max_chars = value;
    else cfg_count_only = value[0];
    apb_xfer(1'b0, {idx, 2'b00}, 32'd0, rd);
    if (rd !== wdata) begin
      $error("prdata: expected %h, got %h", wdata, rd);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run builder for the random part: mostly well-formed characters of all
  // three lengths with random payload, some noise, some broken sequences.
  // ---------------------------------------------------------------------------
  task automatic build_run();
    int          nchar;
    int          kind;
    logic [7:0]  b;
    run_bytes.delete();
    nchar = $urandom_range(1, 16);
    repeat (nchar) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        run_bytes.push_back(8'($urandom_range(1, 127)));
      end else if (kind < 62) begin
        run_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
        run_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end else if (kind < 82) begin
        run_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
        run_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
        run_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end else if (kind < 86) begin
        run_bytes.push_back(8'h00);
      end else if (kind < 94) begin
        run_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        // lead followed by something that is not a continuation
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        run_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
        run_bytes.push_back(b);
      end
    end
    // now and then cut the run inside a sequence
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        run_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
      end else begin
        run_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
        if ($urandom_range(0, 1) == 0) run_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One, two and three byte forms, overlong forms included, at reset config.
  task automatic test_forms();
    run_bytes = {8'h7F, 8'hC0, 8'h80, 8'hDF, 8'hBF};
    send_run();
    run_bytes = {8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF};
    send_run();
    wait_drained();
  endtask

  // Zero byte, bad lead, bad continuation, sequence cut by the run's end.
  task automatic test_stops();
    run_bytes = {8'h00, 8'h41};
    send_run();
    run_bytes = {8'h80};
    send_run();
    run_bytes = {8'hC3, 8'h41};
    send_run();
    run_bytes = {8'hE2, 8'h82};
    send_run();
    wait_drained();
  endtask

  // Output limit, truncation together with a stop, count-only mode.
  task automatic test_limits();
    set_register(REG_MAX_CHARS, 16'd0);
    run_bytes = {8'h41};
    send_run();
    wait_drained();
    set_register(REG_MAX_CHARS, 16'd1);
    run_bytes = {8'h41, 8'h42, 8'h00};
    send_run();
    wait_drained();
    set_register(REG_COUNT_ONLY, 16'd1);
    run_bytes = {8'h41, 8'h42};
    send_run();
    wait_drained();
  endtask

  // Random runs over a spread of settings, extremes included.
  task automatic test_random_runs();
    int          sent;
    int          ph;
    logic [15:0] lim;
    logic        co;
    sent = 0;
    ph = 0;
    while (sent < RANDOM_BYTES) begin
      co = 1'b0;
      case (ph % 6)
        0: lim = 16'hFFFF;
        1: lim = 16'd0;
        2: lim = 16'd1;
        3: lim = 16'($urandom_range(2, 12));
        4: begin
          lim = 16'($urandom_range(0, 8));
          co = 1'b1;
        end
        default: lim = 16'($urandom_range(0, 65535));
      endcase
      set_register(REG_MAX_CHARS, lim);
      set_register(REG_COUNT_ONLY, {15'd0, co});
      // every third phase runs without source gaps
      steady_source = (ph % 3 == 2);
      repeat ($urandom_range(4, 10)) begin
        build_run();
        send_run();
        sent += run_bytes.size();
      end
      wait_drained();
      ph++;
    end
    steady_source = 1'b0;
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_forms();
    test_stops();
    test_limits();
    test_random_runs();
    if (expected_words.size() != 0) begin
      $error("words never seen: %0d", expected_words.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: hold m_tready on a pattern that changes mode now and then.
  // ---------------------------------------------------------------------------
  sink_mode_e  sink_mode = SINK_OPEN;
  int unsigned sink_left = 0;
  int unsigned sink_tick = 0;

  always @(negedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(32, 256);
    end
    sink_left--;
    sink_tick++;
    case (sink_mode)
      SINK_OPEN:     m_tready <= 1'b1;
      SINK_COIN:     m_tready <= 1'($urandom_range(0, 1));
      SINK_PERIODIC: m_tready <= (sink_tick % 11) >= 7;
      default:       m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each accepted word with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_words
    decoded_word_t w;
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: code_unit %h end_of_run %b status %0d char_count %0d",
               m_tdata[15:0], m_tlast, m_tuser, m_tdata[31:16]);
        fail_count++;
      end else begin
        w = expected_words.pop_front();
        if (m_tdata[15:0] !== w.code_unit) begin
          $error("code_unit: expected %h, got %h", w.code_unit, m_tdata[15:0]);
          fail_count++;
        end
        if (m_tlast !== w.end_of_run) begin
          $error("end_of_run: expected %b, got %b", w.end_of_run, m_tlast);
          fail_count++;
        end
        if (m_tuser !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, m_tuser);
          fail_count++;
        end
        if (m_tdata[31:16] !== w.char_count) begin
          $error("char_count: expected %0d, got %0d", w.char_count, m_tdata[31:16]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: give up when nothing has moved for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
